// ----- sv/dsa_pkg.sv -----
package dsa_pkg;

    // stack depths of the two heaps
    localparam int RESOURCE_SLOTS = 4096;
    localparam int SAMPLER_SLOTS  = 2048;

    localparam int RES_AW   = $clog2(RESOURCE_SLOTS);
    localparam int SMP_AW   = $clog2(SAMPLER_SLOTS);
    localparam int RES_CNTW = $clog2(RESOURCE_SLOTS + 1);
    localparam int SMP_CNTW = $clog2(SAMPLER_SLOTS + 1);

    // field widths
    localparam int SLOT_W   = 12;
    localparam int STATUS_W = 3;
    localparam int RES_CAPW = 13;
    localparam int SMP_CAPW = 12;
    localparam int CFG_DW   = 13;
    localparam int CFG_IW   = 2;

    // opcodes
    localparam logic OP_ALLOC   = 1'b0;
    localparam logic OP_RELEASE = 1'b1;

    // heap select
    localparam logic HEAP_RES = 1'b0;
    localparam logic HEAP_SMP = 1'b1;

    // result status codes
    localparam logic [STATUS_W-1:0] ST_REUSED   = 3'd0;
    localparam logic [STATUS_W-1:0] ST_FRESH    = 3'd1;
    localparam logic [STATUS_W-1:0] ST_GROWN    = 3'd2;
    localparam logic [STATUS_W-1:0] ST_FULL     = 3'd3;
    localparam logic [STATUS_W-1:0] ST_RELEASED = 3'd4;
    localparam logic [STATUS_W-1:0] ST_DROPPED  = 3'd5;

    // register indexes
    localparam logic [CFG_IW-1:0] CFG_MAX_RES  = 2'd0;
    localparam logic [CFG_IW-1:0] CFG_MAX_SMP  = 2'd1;
    localparam logic [CFG_IW-1:0] CFG_INIT_CAP = 2'd2;

    // register reset values
    localparam logic [RES_CAPW-1:0] RST_MAX_RES  = 13'd4096;
    localparam logic [SMP_CAPW-1:0] RST_MAX_SMP  = 12'd2048;
    localparam logic [SMP_CAPW-1:0] RST_INIT_CAP = 12'd256;

    // zero acts as one, clamp to stack depth
    function automatic logic [RES_CAPW-1:0] res_eff_max(input logic [RES_CAPW-1:0] m);
        logic [RES_CAPW-1:0] v;
        v = (m == '0) ? RES_CAPW'(1) : m;
        if (32'(v) > RESOURCE_SLOTS)
            v = RES_CAPW'(RESOURCE_SLOTS);
        return v;
    endfunction

    function automatic logic [SMP_CAPW-1:0] smp_eff_max(input logic [SMP_CAPW-1:0] m);
        logic [SMP_CAPW-1:0] v;
        v = (m == '0) ? SMP_CAPW'(1) : m;
        if (32'(v) > SAMPLER_SLOTS)
            v = SMP_CAPW'(SAMPLER_SLOTS);
        return v;
    endfunction

    // starting capacity: at least two, then clamped to the maximum
    function automatic logic [RES_CAPW-1:0] start_cap(input logic [SMP_CAPW-1:0] init,
                                                      input logic [RES_CAPW-1:0] mx);
        logic [RES_CAPW-1:0] v;
        v = (init < SMP_CAPW'(2)) ? RES_CAPW'(2) : RES_CAPW'(init);
        return (v > mx) ? mx : v;
    endfunction

endpackage

// ----- sv/dsa_req_if.sv -----
interface dsa_req_if;
    import dsa_pkg::*;

    logic              valid;
    logic              ready;
    logic              opcode;
    logic              heap_select;
    logic [SLOT_W-1:0] release_index;

    modport source (output valid, output opcode, output heap_select, output release_index,
                    input ready);
    modport sink   (input valid, input opcode, input heap_select, input release_index,
                    output ready);
endinterface

// ----- sv/dsa_rsp_if.sv -----
interface dsa_rsp_if;
    import dsa_pkg::*;

    logic                valid;
    logic                ready;
    logic [SLOT_W-1:0]   slot;
    logic [STATUS_W-1:0] status;
    logic [RES_CAPW-1:0] capacity;

    modport source (output valid, output slot, output status, output capacity,
                    input ready);
    modport sink   (input valid, input slot, input status, input capacity,
                    output ready);
endinterface

// ----- sv/descriptor_slot_allocator_core.sv -----
// Descriptor slot allocator: two slot heaps (resource, sampler), each with a LIFO
// stack of released slots held in a single-port RAM, a bump pointer and a capacity
// that grows by half (clamped to the heap maximum) when the bump pointer hits it.
// Every request item gives exactly one result item. The block takes one item per
// cycle unless results back up, via a request and a result register (a pop's RAM
// read is registered with the result). Stack contents are not cleared after
// reset, so the block is ready as soon as reset is released. A write to any of the
// three registers re-initialises both heaps (empty stacks, bump pointers at zero,
// capacities reloaded); write only with no item in flight; the block doesn't check.
module descriptor_slot_allocator_core (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_we,
    input  logic [dsa_pkg::CFG_IW-1:0]  cfg_index,
    input  logic [dsa_pkg::CFG_DW-1:0]  cfg_data,
    dsa_req_if.sink                     req,
    dsa_rsp_if.source                   rsp
);
    import dsa_pkg::*;

    // configuration registers
    logic [RES_CAPW-1:0] max_res_reg, max_res_next;
    logic [SMP_CAPW-1:0] max_smp_reg, max_smp_next;
    logic [SMP_CAPW-1:0] init_cap_reg, init_cap_next;
    logic                cfg_hit;

    // heap state
    logic [RES_CNTW-1:0] res_cnt_reg, res_cnt_next;
    logic [RES_CAPW-1:0] res_bump_reg, res_bump_next;
    logic [RES_CAPW-1:0] res_cap_reg, res_cap_next;
    logic [SMP_CNTW-1:0] smp_cnt_reg, smp_cnt_next;
    logic [SMP_CAPW-1:0] smp_bump_reg, smp_bump_next;
    logic [SMP_CAPW-1:0] smp_cap_reg, smp_cap_next;

    // request register
    logic              s1_valid_reg;
    logic              s1_op_reg;
    logic              s1_heap_reg;
    logic [SLOT_W-1:0] s1_index_reg;

    // result register
    logic                out_valid_reg;
    logic [SLOT_W-1:0]   out_slot_reg, out_slot_next;
    logic [STATUS_W-1:0] out_status_reg, out_status_next;
    logic [RES_CAPW-1:0] out_cap_reg, out_cap_next;
    logic                out_pop_reg;
    logic                out_heap_reg;

    logic adv;

    // effective maxima
    logic [RES_CAPW-1:0] res_mx;
    logic [SMP_CAPW-1:0] smp_mx;

    // resource heap datapath
    logic                res_act, res_full, res_push, res_pop, res_new;
    logic                res_need_grow, res_at_max, res_bump_ok, res_grow;
    logic [RES_CAPW:0]   res_grown;
    logic [RES_CAPW-1:0] res_cap_grown;
    logic [RES_CNTW-1:0] res_cnt_dec;
    logic [RES_AW-1:0]   res_addr;
    logic [SLOT_W-1:0]   res_rdata;

    // sampler heap datapath
    logic                smp_act, smp_full, smp_push, smp_pop, smp_new;
    logic                smp_need_grow, smp_at_max, smp_bump_ok, smp_grow;
    logic [SMP_CAPW:0]   smp_grown;
    logic [SMP_CAPW-1:0] smp_cap_grown;
    logic [SMP_CNTW-1:0] smp_cnt_dec;
    logic [SMP_AW-1:0]   smp_addr;
    logic [SLOT_W-1:0]   smp_rdata;

    // request stage moves on whenever the result register is free or being emptied
    assign adv       = s1_valid_reg && (!out_valid_reg || rsp.ready);
    assign req.ready = !s1_valid_reg || adv;

    // configuration decode; an index beyond the list is ignored
    assign cfg_hit = cfg_we && (cfg_index == CFG_MAX_RES || cfg_index == CFG_MAX_SMP ||
                                cfg_index == CFG_INIT_CAP);

    always_comb
    begin
        max_res_next  = max_res_reg;
        max_smp_next  = max_smp_reg;
        init_cap_next = init_cap_reg;
        if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_MAX_RES:  max_res_next  = cfg_data;
                CFG_MAX_SMP:  max_smp_next  = cfg_data[SMP_CAPW-1:0];
                CFG_INIT_CAP: init_cap_next = cfg_data[SMP_CAPW-1:0];
                default:      ;
            endcase
        end
    end

    assign res_mx = res_eff_max(max_res_reg);
    assign smp_mx = smp_eff_max(max_smp_reg);

    // resource heap: push on release unless full, pop when stack holds entries, else bump
    assign res_act       = adv && (s1_heap_reg == HEAP_RES);
    assign res_full      = (res_cnt_reg == RES_CNTW'(RESOURCE_SLOTS));
    assign res_push      = res_act && (s1_op_reg == OP_RELEASE) && !res_full;
    assign res_pop       = res_act && (s1_op_reg == OP_ALLOC) && (res_cnt_reg != '0);
    assign res_new       = res_act && (s1_op_reg == OP_ALLOC) && (res_cnt_reg == '0);
    assign res_need_grow = (res_bump_reg >= res_cap_reg);
    assign res_at_max    = (res_cap_reg >= res_mx);
    assign res_bump_ok   = res_new && !(res_need_grow && res_at_max);
    assign res_grow      = res_new && res_need_grow && !res_at_max;
    assign res_grown     = {1'b0, res_cap_reg} + {2'b00, res_cap_reg[RES_CAPW-1:1]};
    assign res_cap_grown = (res_grown > {1'b0, res_mx}) ? res_mx : res_grown[RES_CAPW-1:0];
    assign res_cnt_dec   = res_cnt_reg - RES_CNTW'(1);
    assign res_addr      = res_pop ? res_cnt_dec[RES_AW-1:0] : res_cnt_reg[RES_AW-1:0];

    // sampler heap, same scheme
    assign smp_act       = adv && (s1_heap_reg == HEAP_SMP);
    assign smp_full      = (smp_cnt_reg == SMP_CNTW'(SAMPLER_SLOTS));
    assign smp_push      = smp_act && (s1_op_reg == OP_RELEASE) && !smp_full;
    assign smp_pop       = smp_act && (s1_op_reg == OP_ALLOC) && (smp_cnt_reg != '0);
    assign smp_new       = smp_act && (s1_op_reg == OP_ALLOC) && (smp_cnt_reg == '0);
    assign smp_need_grow = (smp_bump_reg >= smp_cap_reg);
    assign smp_at_max    = (smp_cap_reg >= smp_mx);
    assign smp_bump_ok   = smp_new && !(smp_need_grow && smp_at_max);
    assign smp_grow      = smp_new && smp_need_grow && !smp_at_max;
    assign smp_grown     = {1'b0, smp_cap_reg} + {2'b00, smp_cap_reg[SMP_CAPW-1:1]};
    assign smp_cap_grown = (smp_grown > {1'b0, smp_mx}) ? smp_mx : smp_grown[SMP_CAPW-1:0];
    assign smp_cnt_dec   = smp_cnt_reg - SMP_CNTW'(1);
    assign smp_addr      = smp_pop ? smp_cnt_dec[SMP_AW-1:0] : smp_cnt_reg[SMP_AW-1:0];

    // free stacks; the sampler stack keeps the full 12-bit index as given
    dsa_ram #(.DEPTH(RESOURCE_SLOTS), .WIDTH(SLOT_W)) u_res_stack (
        .clk   (clk),
        .we    (res_push),
        .re    (res_pop),
        .addr  (res_addr),
        .wdata (s1_index_reg),
        .rdata (res_rdata)
    );

    dsa_ram #(.DEPTH(SAMPLER_SLOTS), .WIDTH(SLOT_W)) u_smp_stack (
        .clk   (clk),
        .we    (smp_push),
        .re    (smp_pop),
        .addr  (smp_addr),
        .wdata (s1_index_reg),
        .rdata (smp_rdata)
    );

    // next heap state; a register write reloads both heaps from the new values
    always_comb
    begin
        res_cnt_next  = res_cnt_reg;
        res_bump_next = res_bump_reg;
        res_cap_next  = res_cap_reg;
        smp_cnt_next  = smp_cnt_reg;
        smp_bump_next = smp_bump_reg;
        smp_cap_next  = smp_cap_reg;
        if (cfg_hit)
        begin
            res_cnt_next  = '0;
            res_bump_next = '0;
            res_cap_next  = start_cap(init_cap_next, res_eff_max(max_res_next));
            smp_cnt_next  = '0;
            smp_bump_next = '0;
            smp_cap_next  = SMP_CAPW'(start_cap(init_cap_next,
                                                {1'b0, smp_eff_max(max_smp_next)}));
        end
        else
        begin
            if (res_push)
                res_cnt_next = res_cnt_reg + RES_CNTW'(1);
            if (res_pop)
                res_cnt_next = res_cnt_dec;
            if (res_bump_ok)
                res_bump_next = res_bump_reg + RES_CAPW'(1);
            if (res_grow)
                res_cap_next = res_cap_grown;
            if (smp_push)
                smp_cnt_next = smp_cnt_reg + SMP_CNTW'(1);
            if (smp_pop)
                smp_cnt_next = smp_cnt_dec;
            if (smp_bump_ok)
                smp_bump_next = smp_bump_reg + SMP_CAPW'(1);
            if (smp_grow)
                smp_cap_next = smp_cap_grown;
        end
    end

    // result fields for the selected heap
    always_comb
    begin
        out_slot_next = '0;
        if (s1_heap_reg == HEAP_SMP)
        begin
            out_cap_next = {1'b0, smp_cap_next};
            if (s1_op_reg == OP_RELEASE)
                out_status_next = smp_full ? ST_DROPPED : ST_RELEASED;
            else if (smp_cnt_reg != '0)
                out_status_next = ST_REUSED;
            else if (!smp_need_grow)
                out_status_next = ST_FRESH;
            else if (smp_at_max)
                out_status_next = ST_FULL;
            else
                out_status_next = ST_GROWN;
            if (smp_bump_ok)
                out_slot_next = smp_bump_reg;
        end
        else
        begin
            out_cap_next = res_cap_next;
            if (s1_op_reg == OP_RELEASE)
                out_status_next = res_full ? ST_DROPPED : ST_RELEASED;
            else if (res_cnt_reg != '0)
                out_status_next = ST_REUSED;
            else if (!res_need_grow)
                out_status_next = ST_FRESH;
            else if (res_at_max)
                out_status_next = ST_FULL;
            else
                out_status_next = ST_GROWN;
            if (res_bump_ok)
                out_slot_next = res_bump_reg[SLOT_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_res_reg   <= RST_MAX_RES;
            max_smp_reg   <= RST_MAX_SMP;
            init_cap_reg  <= RST_INIT_CAP;
            res_cnt_reg   <= '0;
            res_bump_reg  <= '0;
            res_cap_reg   <= start_cap(RST_INIT_CAP, res_eff_max(RST_MAX_RES));
            smp_cnt_reg   <= '0;
            smp_bump_reg  <= '0;
            smp_cap_reg   <= SMP_CAPW'(start_cap(RST_INIT_CAP,
                                                 {1'b0, smp_eff_max(RST_MAX_SMP)}));
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            max_res_reg  <= max_res_next;
            max_smp_reg  <= max_smp_next;
            init_cap_reg <= init_cap_next;
            res_cnt_reg  <= res_cnt_next;
            res_bump_reg <= res_bump_next;
            res_cap_reg  <= res_cap_next;
            smp_cnt_reg  <= smp_cnt_next;
            smp_bump_reg <= smp_bump_next;
            smp_cap_reg  <= smp_cap_next;
            if (req.ready)
                s1_valid_reg <= req.valid;
            if (adv)
                out_valid_reg <= 1'b1;
            else if (rsp.ready)
                out_valid_reg <= 1'b0;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (req.valid && req.ready)
        begin
            s1_op_reg    <= req.opcode;
            s1_heap_reg  <= req.heap_select;
            s1_index_reg <= req.release_index;
        end
        if (adv)
        begin
            out_slot_reg   <= out_slot_next;
            out_status_reg <= out_status_next;
            out_cap_reg    <= out_cap_next;
            out_pop_reg    <= res_pop || smp_pop;
            out_heap_reg   <= s1_heap_reg;
        end
    end

    // popped slot comes straight from the registered stack read
    assign rsp.valid    = out_valid_reg;
    assign rsp.slot     = !out_pop_reg ? out_slot_reg :
                          (out_heap_reg == HEAP_SMP) ? smp_rdata : res_rdata;
    assign rsp.status   = out_status_reg;
    assign rsp.capacity = out_cap_reg;

    // resource capacity never passes the effective maximum
    a_res_cap: assert property (@(posedge clk) disable iff (!rst_n)
        res_cap_reg <= res_mx)
        else $error("resource capacity above maximum");

    // bump pointer stays within capacity
    a_bump: assert property (@(posedge clk) disable iff (!rst_n)
        res_bump_reg <= res_cap_reg && smp_bump_reg <= smp_cap_reg)
        else $error("bump pointer beyond capacity");

    // stack fill never passes its depth
    a_cnt: assert property (@(posedge clk) disable iff (!rst_n)
        32'(res_cnt_reg) <= RESOURCE_SLOTS && 32'(smp_cnt_reg) <= SAMPLER_SLOTS)
        else $error("stack count beyond depth");

    // a held request stays in the request register
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg && !adv |=> s1_valid_reg && $stable(s1_index_reg))
        else $error("held request lost");
endmodule

// ----- sv/dsa_ram.sv -----
module dsa_ram #(
    parameter int DEPTH = 4096,
    parameter int WIDTH = 12
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
            mem[addr] <= wdata;
        if (re)
            rdata_reg <= mem[addr];
    end

    assign rdata = rdata_reg;
endmodule
